// ----- hw/rtl/dta_pkg.sv -----
package dta_pkg;

  typedef enum logic [2:0] {
    ACT_LOAD    = 3'd0,
    ACT_SECONDS = 3'd1,
    ACT_MINUTES = 3'd2,
    ACT_HOURS   = 3'd3,
    ACT_DAYS    = 3'd4,
    ACT_YEARS   = 3'd5
  } action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] amount;
    logic [15:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic        year_overflow;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_CYC  = 5'b00100,
    ST_MON  = 5'b01000,
    ST_EMIT = 5'b10000
  } fsm_e;

  // which carry stage the shared divide unit is serving
  typedef enum logic [1:0] {
    STG_SEC  = 2'd0,
    STG_MIN  = 2'd1,
    STG_HOUR = 2'd2,
    STG_YEAR = 2'd3
  } stage_e;

  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned MIN_PER_HOUR  = 60;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned CYCLE_YEARS   = 400;
  localparam int unsigned CYCLE_DAYS    = 146097;
  localparam int unsigned YEAR_MAX      = 65535;
  localparam int unsigned LEAP_FEB_DAYS = 29;

  // reciprocal multiply for the constant divides, exact for numerators below 2**DIV_W
  localparam int unsigned DIV_W     = 17;
  localparam int unsigned RECIP_W   = 18;
  localparam int unsigned RECIP_60  = 139811;
  localparam int unsigned SHIFT_60  = 23;
  localparam int unsigned RECIP_24  = 174763;
  localparam int unsigned SHIFT_24  = 22;
  localparam int unsigned RECIP_400 = 167773;
  localparam int unsigned SHIFT_400 = 26;

  localparam logic [4:0] MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

endpackage

// ----- hw/rtl/date_time_adder.sv -----
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  in_data_i  (dta_pkg::in_item_t)
// out       output     out_valid_o / out_ready_i out_data_o (dta_pkg::out_item_t)
//
// One transaction at a time; in_ready_o is high only while the sequencer is idle.
// Load, add years and unused codes go from acceptance straight to the emit state.
// Add s/min/h: each carry stage taken is a reciprocal multiply, then a remainder;
// reaching days adds year mod 400, then the 400-year steps and the months rolled.
// Add days: year mod 400, then 400-year steps, then months rolled; the month loop dominates.
// Reset returns the date to 0001-01-01 00:00:00; a stalled result holds in the
// output register while the next transaction is accepted; its emit then waits.
module date_time_adder #(
  parameter int AMOUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dta_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dta_pkg::out_item_t  out_data_o
);

  localparam int SumW  = AMOUNT_WIDTH + 1;
  localparam int WorkW = (SumW > 18) ? SumW : 18;
  localparam int DivW  = dta_pkg::DIV_W;
  localparam int RecW  = dta_pkg::RECIP_W;
  localparam int ProdW = DivW + RecW;

  function automatic logic is_leap(input logic [8:0] r);
    is_leap = (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    if (m == 4'd2 && leap) begin
      days_in = 5'(dta_pkg::LEAP_FEB_DAYS);
    end else if (m >= 4'd1 && m <= 4'd12) begin
      days_in = dta_pkg::MONTH_LEN[m];
    end else begin
      days_in = dta_pkg::MONTH_LEN[1];
    end
  endfunction

  dta_pkg::fsm_e   fsm_q, fsm_d;
  dta_pkg::stage_e stage_q, stage_d;
  logic [15:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic        out_valid_q, out_valid_d;
  dta_pkg::out_item_t out_q, out_d;
  logic        ovf_q, ovf_d;

  logic [DivW-1:0]  num_q, num_d;
  logic [DivW-1:0]  quo_q, quo_d;
  logic             div_ph_q, div_ph_d;
  logic [WorkW-1:0] dacc_q, dacc_d;
  logic [15:0]      yw_q, yw_d;
  logic [3:0]       mw_q, mw_d;
  logic [8:0]       r400_q, r400_d;

  logic [AMOUNT_WIDTH-1:0] amt;
  logic [8:0]       divisor;
  logic [RecW-1:0]  recip;
  logic [ProdW-1:0] prod;
  logic [DivW-1:0]  quo_mul;
  logic [DivW-1:0]  qd;
  logic [8:0]       rem;
  logic [4:0]       dim;
  logic [16:0]      ysum;
  logic [WorkW-1:0] ywide;
  logic             sat;
  logic [3:0]       ld_month;
  logic [4:0]       ld_day;

  assign amt = AMOUNT_WIDTH'(in_data_i.amount);
  assign in_ready_o  = (fsm_q == dta_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    case (stage_q)
      dta_pkg::STG_SEC: begin
        divisor = 9'(dta_pkg::SEC_PER_MIN);
        recip   = RecW'(dta_pkg::RECIP_60);
      end
      dta_pkg::STG_MIN: begin
        divisor = 9'(dta_pkg::MIN_PER_HOUR);
        recip   = RecW'(dta_pkg::RECIP_60);
      end
      dta_pkg::STG_HOUR: begin
        divisor = 9'(dta_pkg::HOURS_PER_DAY);
        recip   = RecW'(dta_pkg::RECIP_24);
      end
      default: begin
        divisor = 9'(dta_pkg::CYCLE_YEARS);
        recip   = RecW'(dta_pkg::RECIP_400);
      end
    endcase
  end

  // shared divide unit: quotient by reciprocal multiply, registered, then remainder
  assign prod = ProdW'(num_q) * ProdW'(recip);

  always_comb begin
    case (stage_q)
      dta_pkg::STG_SEC:  quo_mul = DivW'(prod >> dta_pkg::SHIFT_60);
      dta_pkg::STG_MIN:  quo_mul = DivW'(prod >> dta_pkg::SHIFT_60);
      dta_pkg::STG_HOUR: quo_mul = DivW'(prod >> dta_pkg::SHIFT_24);
      default:           quo_mul = DivW'(prod >> dta_pkg::SHIFT_400);
    endcase
  end

  assign qd  = quo_q * DivW'(divisor);
  assign rem = 9'(num_q - qd);
  assign dim = days_in(mw_q, is_leap(r400_q));

  always_comb begin
    fsm_d       = fsm_q;
    stage_d     = stage_q;
    year_d      = year_q;
    month_d     = month_q;
    day_d       = day_q;
    hour_d      = hour_q;
    minute_d    = minute_q;
    second_d    = second_q;
    ovf_d       = ovf_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    num_d       = num_q;
    quo_d       = quo_q;
    div_ph_d    = div_ph_q;
    dacc_d      = dacc_q;
    yw_d        = yw_q;
    mw_d        = mw_q;
    r400_d      = r400_q;
    sat         = 1'b0;
    ysum        = '0;
    ywide       = '0;
    ld_month    = in_data_i.load_month;
    ld_day      = in_data_i.load_day;

    case (fsm_q)
      dta_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ovf_d    = 1'b0;
          div_ph_d = 1'b0;
          case (in_data_i.action)
            dta_pkg::ACT_LOAD: begin
              if (ld_month == 4'd0) ld_month = 4'd1;
              if (ld_month > 4'd12) ld_month = 4'd12;
              if (ld_day == 5'd0) ld_day = 5'd1;
              year_d   = in_data_i.load_year;
              month_d  = ld_month;
              day_d    = ld_day;
              hour_d   = in_data_i.load_hour;
              minute_d = in_data_i.load_minute;
              second_d = in_data_i.load_second;
              fsm_d    = dta_pkg::ST_EMIT;
            end
            dta_pkg::ACT_SECONDS: begin
              num_d   = DivW'(second_q) + DivW'(amt);
              stage_d = dta_pkg::STG_SEC;
              fsm_d   = dta_pkg::ST_DIV;
            end
            dta_pkg::ACT_MINUTES: begin
              num_d   = DivW'(minute_q) + DivW'(amt);
              stage_d = dta_pkg::STG_MIN;
              fsm_d   = dta_pkg::ST_DIV;
            end
            dta_pkg::ACT_HOURS: begin
              num_d   = DivW'(hour_q) + DivW'(amt);
              stage_d = dta_pkg::STG_HOUR;
              fsm_d   = dta_pkg::ST_DIV;
            end
            dta_pkg::ACT_DAYS: begin
              dacc_d  = WorkW'(day_q) + WorkW'(amt);
              num_d   = DivW'(year_q);
              stage_d = dta_pkg::STG_YEAR;
              fsm_d   = dta_pkg::ST_DIV;
            end
            dta_pkg::ACT_YEARS: begin
              ywide = WorkW'(year_q) + WorkW'(amt);
              if (ywide > WorkW'(dta_pkg::YEAR_MAX)) begin
                year_d = 16'(dta_pkg::YEAR_MAX);
                ovf_d  = 1'b1;
              end else begin
                year_d = ywide[15:0];
              end
              fsm_d = dta_pkg::ST_EMIT;
            end
            default: begin
              fsm_d = dta_pkg::ST_EMIT;
            end
          endcase
        end
      end

      dta_pkg::ST_DIV: begin
        if (!div_ph_q) begin
          quo_d    = quo_mul;
          div_ph_d = 1'b1;
        end else begin
          div_ph_d = 1'b0;
          fsm_d    = dta_pkg::ST_EMIT;
          case (stage_q)
            dta_pkg::STG_SEC: begin
              second_d = rem[5:0];
              if (quo_q != '0) begin
                num_d   = DivW'(minute_q) + quo_q;
                stage_d = dta_pkg::STG_MIN;
                fsm_d   = dta_pkg::ST_DIV;
              end
            end
            dta_pkg::STG_MIN: begin
              minute_d = rem[5:0];
              if (quo_q != '0) begin
                num_d   = DivW'(hour_q) + quo_q;
                stage_d = dta_pkg::STG_HOUR;
                fsm_d   = dta_pkg::ST_DIV;
              end
            end
            dta_pkg::STG_HOUR: begin
              hour_d = rem[4:0];
              if (quo_q != '0) begin
                dacc_d  = WorkW'(day_q) + WorkW'(quo_q);
                num_d   = DivW'(year_q);
                stage_d = dta_pkg::STG_YEAR;
                fsm_d   = dta_pkg::ST_DIV;
              end
            end
            default: begin
              // year mod 400 drives the leap test while months roll
              r400_d = rem;
              yw_d   = year_q;
              mw_d   = month_q;
              fsm_d  = dta_pkg::ST_CYC;
            end
          endcase
        end
      end

      dta_pkg::ST_CYC: begin
        if (dacc_q > WorkW'(dta_pkg::CYCLE_DAYS + 32'd31)) begin
          dacc_d = dacc_q - WorkW'(dta_pkg::CYCLE_DAYS);
          ysum   = {1'b0, yw_q} + 17'(dta_pkg::CYCLE_YEARS);
          if (ysum > 17'(dta_pkg::YEAR_MAX)) begin
            sat = 1'b1;
          end else begin
            yw_d = ysum[15:0];
          end
        end else begin
          fsm_d = dta_pkg::ST_MON;
        end
      end

      dta_pkg::ST_MON: begin
        if (dacc_q > WorkW'(dim)) begin
          dacc_d = dacc_q - WorkW'(dim);
          if (mw_q == 4'd12) begin
            ysum = {1'b0, yw_q} + 17'd1;
            if (ysum > 17'(dta_pkg::YEAR_MAX)) begin
              sat = 1'b1;
            end else begin
              yw_d   = ysum[15:0];
              mw_d   = 4'd1;
              r400_d = (r400_q == 9'(dta_pkg::CYCLE_YEARS - 1)) ? 9'd0 : r400_q + 9'd1;
            end
          end else begin
            mw_d = mw_q + 4'd1;
          end
        end else begin
          year_d  = yw_q;
          month_d = mw_q;
          day_d   = dacc_q[4:0];
          fsm_d   = dta_pkg::ST_EMIT;
        end
      end

      dta_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.cur_year      = year_q;
          out_d.cur_month     = month_q;
          out_d.cur_day       = day_q;
          out_d.cur_hour      = hour_q;
          out_d.cur_minute    = minute_q;
          out_d.cur_second    = second_q;
          out_d.year_overflow = ovf_q;
          out_valid_d         = 1'b1;
          fsm_d               = dta_pkg::ST_IDLE;
        end
      end

      default: begin
        fsm_d = dta_pkg::ST_IDLE;
      end
    endcase

    // calendar overflow pins everything to the last representable second
    if (sat) begin
      year_d   = 16'(dta_pkg::YEAR_MAX);
      month_d  = 4'd12;
      day_d    = 5'd31;
      hour_d   = 5'd23;
      minute_d = 6'd59;
      second_d = 6'd59;
      ovf_d    = 1'b1;
      fsm_d    = dta_pkg::ST_EMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= dta_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      year_q      <= 16'd1;
      month_q     <= 4'd1;
      day_q       <= 5'd1;
      hour_q      <= 5'd0;
      minute_q    <= 6'd0;
      second_q    <= 6'd0;
    end else begin
      fsm_q       <= fsm_d;
      out_valid_q <= out_valid_d;
      year_q      <= year_d;
      month_q     <= month_d;
      day_q       <= day_d;
      hour_q      <= hour_d;
      minute_q    <= minute_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q  <= stage_d;
    ovf_q    <= ovf_d;
    out_q    <= out_d;
    num_q    <= num_d;
    quo_q    <= quo_d;
    div_ph_q <= div_ph_d;
    dacc_q   <= dacc_d;
    yw_q     <= yw_d;
    mw_q     <= mw_d;
    r400_q   <= r400_d;
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a transaction while still busy");

  a_ovf_year_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.year_overflow |-> out_data_o.cur_year == 16'hFFFF)
    else $error("overflow flagged without saturated year");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q == dta_pkg::ST_MON |-> mw_q >= 4'd1 && mw_q <= 4'd12)
    else $error("month out of range during roll");

  a_emit_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q == dta_pkg::ST_EMIT && (!out_valid_o || out_ready_i) |=> out_valid_o)
    else $error("result not presented after emit");

endmodule
